[rtl/hsl_to_rgba_converter_defines.svh]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - assertion macros
// Shared concurrent assertion forms for the converter's checker.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGBA_CONVERTER_DEFINES_SVH
`define HSL_TO_RGBA_CONVERTER_DEFINES_SVH

// property checked on every clock edge outside reset
`define HSLC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// property checked on every clock edge, reset included
`define HSLC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[rtl/hslc_pkg.sv]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - package
// Field widths, hue constants and shared types.
// ----------------------------------------------------------------------------
package hslc_pkg;

    localparam int FRAC_BITS_DEF = 16;     // fraction bits, ONE = 2**FRAC_BITS

    localparam int HUE_W  = 13;            // hue field
    localparam int FRAC_W = 17;            // saturation / lightness / opacity fields
    localparam int CHAN_W = 8;             // output channel
    localparam int WT_W   = 10;            // ramp weight, 0..960

    localparam int HUE_TURN  = 5760;       // full turn in 1/16 degree
    localparam int HUE_THIRD = 1920;
    localparam int HUE_B1    = 960;
    localparam int HUE_B2    = 2880;
    localparam int HUE_B3    = 3840;

    localparam int GREY_DIV  = 200000;     // grey when s * GREY_DIV < ONE

    // per-stage advance strobes for the channel ramp datapath
    typedef struct packed {
        logic adv_mul;
        logic adv_sum;
        logic adv_out;
    } t_chan_ctl;

endpackage

[rtl/hslc_if.sv]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - stream interfaces
// Valid/ready channels for HSLA input words and RGBA output words.
// ----------------------------------------------------------------------------
interface hslc_in_if;
    logic                              valid;
    logic                              ready;
    logic [hslc_pkg::HUE_W-1:0]        hue;
    logic [hslc_pkg::FRAC_W-1:0]       saturation;
    logic [hslc_pkg::FRAC_W-1:0]       lightness;
    logic [hslc_pkg::FRAC_W-1:0]       opacity;

    modport source (output valid, hue, saturation, lightness, opacity, input ready);
    modport sink   (input valid, hue, saturation, lightness, opacity, output ready);
endinterface

interface hslc_out_if;
    logic                              valid;
    logic                              ready;
    logic [hslc_pkg::CHAN_W-1:0]       red;
    logic [hslc_pkg::CHAN_W-1:0]       green;
    logic [hslc_pkg::CHAN_W-1:0]       blue;
    logic [hslc_pkg::CHAN_W-1:0]       alpha_out;

    modport source (output valid, red, green, blue, alpha_out, input ready);
    modport sink   (input valid, red, green, blue, alpha_out, output ready);
endinterface

[rtl/hsl_to_rgba_converter.sv]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - top level
// Fixed-point HSLA to 8-bit RGBA, seven-stage pipeline, one word per clock when not stalled.
// ----------------------------------------------------------------------------
//  port     dir  word contents
//  -------  ---  ----------------------------------------------------------
//  i_hsl    in   hue (1/16 deg), saturation, lightness, opacity (ONE = 2**F)
//  o_rgba   out  red, green, blue, alpha_out (8 bits each)
//
//  One word per clock is accepted while the output is not stalled.
//  The two multiply stages (l*s, then the ramp products) set the stage depth.
//  Synchronous active-low reset clears only the stage valid bits.
//  Each stage holds while its successor is full and stalled, so bubbles
//  collapse and a waiting output word never blocks input while holes remain.
// ----------------------------------------------------------------------------
module hsl_to_rgba_converter #(
    parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hslc_in_if.sink     i_hsl,
    hslc_out_if.source  o_rgba
);

    localparam int HW = hslc_pkg::HUE_W;
    localparam int FW = hslc_pkg::FRAC_W;
    localparam int WW = hslc_pkg::WT_W;
    localparam int BW = hslc_pkg::CHAN_W;
    localparam int VW = FRAC_BITS + 1;                 // saturated fraction 0..ONE
    localparam int CW = (VW > FW) ? VW : FW;           // compare width for saturation
    localparam int MW = 2 * FRAC_BITS + 1;             // m1/m2 scaled by ONE*ONE
    localparam int GREY_MAX = ((1 << FRAC_BITS) - 1) / hslc_pkg::GREY_DIV;
    localparam int NSTG = 7;

    localparam logic [CW-1:0] ONE_C  = CW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF_C = VW'(1) << (FRAC_BITS - 1);

    // ramp weights per channel
    typedef struct packed {
        logic [WW-1:0] wr;
        logic [WW-1:0] wg;
        logic [WW-1:0] wb;
    } t_wts;

    // grey bypass and alpha, carried beside the ramp datapath
    typedef struct packed {
        logic          grey;
        logic [BW-1:0] gval;
        logic [BW-1:0] aval;
    } t_side;

    // ---- helpers --------------------------------------------------------
    function automatic logic [VW-1:0] sat_frac(input logic [FW-1:0] v);
        logic [CW-1:0] x;
        x = CW'(v);
        return (x > ONE_C) ? ONE_C[VW-1:0] : x[VW-1:0];
    endfunction

    // floor(v * 255 / ONE), v <= ONE
    function automatic logic [BW-1:0] frac_to_byte(input logic [VW-1:0] v);
        logic [VW+7:0] p;
        p = {v, 8'b0000_0000} - (VW+8)'(v);
        return p[FRAC_BITS+7 : FRAC_BITS];
    endfunction

    // single wrap of a hue below two turns
    function automatic logic [HW-1:0] hue_wrap(input logic [HW:0] t);
        logic [HW:0] d;
        d = (t >= (HW+1)'(hslc_pkg::HUE_TURN)) ? t - (HW+1)'(hslc_pkg::HUE_TURN) : t;
        return d[HW-1:0];
    endfunction

    // piecewise-linear ramp weight: value = m1 + (m2 - m1) * w / 960
    function automatic logic [WW-1:0] ramp_wt(input logic [HW-1:0] t);
        logic [HW-1:0] d;
        logic [WW-1:0] w;
        d = HW'(hslc_pkg::HUE_B3) - t;
        if (t < HW'(hslc_pkg::HUE_B1)) begin
            w = t[WW-1:0];
        end else if (t < HW'(hslc_pkg::HUE_B2)) begin
            w = WW'(hslc_pkg::HUE_B1);
        end else if (t < HW'(hslc_pkg::HUE_B3)) begin
            w = d[WW-1:0];
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // ---- stage control --------------------------------------------------
    logic [NSTG:1] r_v;
    logic [NSTG:1] adv;

    always_comb begin
        adv[NSTG] = !r_v[NSTG] || o_rgba.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    assign i_hsl.ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[1]) begin
                r_v[1] <= i_hsl.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---- datapath -------------------------------------------------------
    // stage 1: saturate fractions, wrap hue
    logic [HW-1:0] r1_hue;
    logic [VW-1:0] r1_s;
    logic [VW-1:0] r1_l;
    logic [VW-1:0] r1_a;

    // stage 2: l*s, channel weights, grey and alpha bytes
    logic [HW-1:0]   hue_r_n;
    logic [HW-1:0]   hue_b_n;
    logic [2*VW-1:0] ls_n;
    logic [MW-1:0]   r2_ls;
    logic [VW-1:0]   r2_s;
    logic [VW-1:0]   r2_l;
    t_wts            r2_wt;
    t_side           r2_sb;

    // stage 3: m2
    logic [MW:0]     m2_lo_n;
    logic [MW:0]     m2_hi_n;
    logic [MW-1:0]   r3_m2x;
    logic [VW-1:0]   r3_l;
    t_wts            r3_wt;

    // stage 4: m1 and m2 - m1
    logic [MW:0]     twol_n;
    logic [MW:0]     m2x2_n;
    logic [MW:0]     m1_n;
    logic [MW:0]     diff_n;
    logic [MW-1:0]   r4_m1x;
    logic [MW-1:0]   r4_diff;
    t_wts            r4_wt;

    // side band for stages 3..7
    t_side           r_sb [3:NSTG];

    assign hue_r_n = hue_wrap((HW+1)'(r1_hue) + (HW+1)'(hslc_pkg::HUE_THIRD));
    // blue: hue + turn - third
    assign hue_b_n = hue_wrap((HW+1)'(r1_hue) + (HW+1)'(hslc_pkg::HUE_B3));
    assign ls_n    = r1_l * r1_s;

    // l <= 1/2: l*(1+s); else (l+s) - l*s
    assign m2_lo_n = (MW+1)'(r2_ls) + ((MW+1)'(r2_l) << FRAC_BITS);
    assign m2_hi_n = (((MW+1)'(r2_l) + (MW+1)'(r2_s)) << FRAC_BITS) - (MW+1)'(r2_ls);

    // m1 = 2l - m2, m2 - m1 = 2*m2 - 2l
    assign twol_n = (MW+1)'(r3_l) << (FRAC_BITS + 1);
    assign m2x2_n = {r3_m2x, 1'b0};
    assign m1_n   = (twol_n >= (MW+1)'(r3_m2x)) ? twol_n - (MW+1)'(r3_m2x) : '0;
    assign diff_n = (m2x2_n >= twol_n) ? m2x2_n - twol_n : '0;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_hue <= hue_wrap({1'b0, i_hsl.hue});
            r1_s   <= sat_frac(i_hsl.saturation);
            r1_l   <= sat_frac(i_hsl.lightness);
            r1_a   <= sat_frac(i_hsl.opacity);
        end
        if (adv[2]) begin
            r2_ls      <= ls_n[MW-1:0];
            r2_s       <= r1_s;
            r2_l       <= r1_l;
            r2_wt.wr   <= ramp_wt(hue_r_n);
            r2_wt.wg   <= ramp_wt(r1_hue);
            r2_wt.wb   <= ramp_wt(hue_b_n);
            r2_sb.grey <= (r1_s <= VW'(GREY_MAX));
            r2_sb.gval <= frac_to_byte(r1_l);
            r2_sb.aval <= frac_to_byte(r1_a);
        end
        if (adv[3]) begin
            r3_m2x <= (r2_l <= HALF_C) ? m2_lo_n[MW-1:0] : m2_hi_n[MW-1:0];
            r3_l   <= r2_l;
            r3_wt  <= r2_wt;
            r_sb[3] <= r2_sb;
        end
        if (adv[4]) begin
            r4_m1x  <= m1_n[MW-1:0];
            r4_diff <= diff_n[MW-1:0];
            r4_wt   <= r3_wt;
        end
        for (int k = 4; k <= NSTG; k++) begin
            if (adv[k]) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // stages 5..7: per-channel ramp
    hslc_pkg::t_chan_ctl chan_ctl;
    logic [BW-1:0]       red_ramp;
    logic [BW-1:0]       green_ramp;
    logic [BW-1:0]       blue_ramp;

    assign chan_ctl.adv_mul = adv[5];
    assign chan_ctl.adv_sum = adv[6];
    assign chan_ctl.adv_out = adv[7];

    hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_m1x  (r4_m1x),
        .i_diff (r4_diff),
        .i_wt   (r4_wt.wr),
        .o_val  (red_ramp)
    );

    hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_m1x  (r4_m1x),
        .i_diff (r4_diff),
        .i_wt   (r4_wt.wg),
        .o_val  (green_ramp)
    );

    hslc_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
        .i_clk  (i_clk),
        .i_ctl  (chan_ctl),
        .i_m1x  (r4_m1x),
        .i_diff (r4_diff),
        .i_wt   (r4_wt.wb),
        .o_val  (blue_ramp)
    );

    // ---- output word ----------------------------------------------------
    assign o_rgba.valid     = r_v[NSTG];
    assign o_rgba.red       = r_sb[NSTG].grey ? r_sb[NSTG].gval : red_ramp;
    assign o_rgba.green     = r_sb[NSTG].grey ? r_sb[NSTG].gval : green_ramp;
    assign o_rgba.blue      = r_sb[NSTG].grey ? r_sb[NSTG].gval : blue_ramp;
    assign o_rgba.alpha_out = r_sb[NSTG].aval;

endmodule

[rtl/hslc_chan.sv]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - channel ramp
// Three register stages: products, ramp sum, scale to 8 bits.
// ----------------------------------------------------------------------------
module hslc_chan #(
    parameter int FRAC_BITS = hslc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  hslc_pkg::t_chan_ctl           i_ctl,
    input  logic [2*FRAC_BITS:0]          i_m1x,    // m1 scaled by ONE*ONE
    input  logic [2*FRAC_BITS:0]          i_diff,   // m2 - m1, same scale
    input  logic [hslc_pkg::WT_W-1:0]     i_wt,     // ramp weight 0..960
    output logic [hslc_pkg::CHAN_W-1:0]   o_val
);

    localparam int MW = 2 * FRAC_BITS + 1;
    localparam int NW = MW + hslc_pkg::WT_W;      // num <= 960 * ONE*ONE

    logic [NW-1:0]                 p1_n;
    logic [NW-1:0]                 p2_n;
    logic [NW+3:0]                 y_n;
    logic [NW-1:0]                 r_p1;
    logic [NW-1:0]                 r_p2;
    logic [NW-1:0]                 r_num;
    logic [hslc_pkg::CHAN_W-1:0]   r_val;

    assign p1_n = NW'(i_m1x) * NW'(hslc_pkg::HUE_B1);
    assign p2_n = NW'(i_diff) * NW'(i_wt);

    // 255/960 = 17/64: value = floor(17 * num / 2**(2F+6)), never above 255
    assign y_n = {r_num, 4'b0000} + (NW+4)'(r_num);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv_mul) begin
            r_p1 <= p1_n;
            r_p2 <= p2_n;
        end
        if (i_ctl.adv_sum) begin
            r_num <= r_p1 + r_p2;
        end
        if (i_ctl.adv_out) begin
            r_val <= y_n[2*FRAC_BITS+13 : 2*FRAC_BITS+6];
        end
    end

    assign o_val = r_val;

endmodule

[rtl/hslc_checker.sv]
// ----------------------------------------------------------------------------
// HSL to RGBA converter - port checker
// Watches the converter's stream ports; bound to the top level.
// ----------------------------------------------------------------------------
`include "hsl_to_rgba_converter_defines.svh"

module hslc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_data
);

    // no word left over from before reset
    `HSLC_ASSERT_RST(a_rst_clears, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // an empty or draining output stage always lets input in
    `HSLC_ASSERT(a_no_false_stall, (!i_out_valid || i_out_ready) |-> i_in_ready,
        "input stalled while output stage free")

    // a stalled output word stays offered
    `HSLC_ASSERT(a_out_hold, $past(i_out_valid && !i_out_ready) |-> i_out_valid,
        "output word dropped under stall")

    // and keeps its value
    `HSLC_ASSERT(a_out_stable, $past(i_out_valid && !i_out_ready) |-> $stable(i_out_data),
        "output word changed under stall")

endmodule

bind hsl_to_rgba_converter hslc_checker u_hslc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsl.valid),
    .i_in_ready  (i_hsl.ready),
    .i_out_valid (o_rgba.valid),
    .i_out_ready (o_rgba.ready),
    .i_out_data  ({o_rgba.red, o_rgba.green, o_rgba.blue, o_rgba.alpha_out})
);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSL to RGBA converter - testbench
// Drives HSLA words through the valid/ready input and predicts each RGBA
// word in fixed point. A scoreboard compares every output word, field by
// field, with the oldest prediction. Both sides idle at random, and the
// output is held off for long stretches so that the pipeline backs up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int                FRAC_W    = hslc_pkg::FRAC_W;
    localparam int                HUE_W     = hslc_pkg::HUE_W;
    localparam int                CHAN_W    = hslc_pkg::CHAN_W;
    localparam int                HUE_TURN  = hslc_pkg::HUE_TURN;
    localparam int                HUE_THIRD = hslc_pkg::HUE_THIRD;
    localparam int                HUE_B1    = hslc_pkg::HUE_B1;
    localparam int                HUE_B2    = hslc_pkg::HUE_B2;
    localparam int                HUE_B3    = hslc_pkg::HUE_B3;
    localparam int                GREY_DIV  = hslc_pkg::GREY_DIV;

    localparam int                FB       = hslc_pkg::FRAC_BITS_DEF;
    localparam longint unsigned   ONE      = 64'd1 << FB;
    localparam int                ONE_I    = 1 << FB;
    localparam int                FRAC_MAX = (1 << FRAC_W) - 1;
    localparam int                HUE_MAX  = (1 << HUE_W) - 1;
    localparam int                HOLD_LEN = 80;      // long output hold-off
    localparam int                LIMIT    = 200000;  // cycle budget for the run
    localparam int                PHASE_N  = 360;     // random words per phase

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] lightness;
        logic [FRAC_W-1:0] opacity;
    } t_hsla_word;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha_out;
    } t_rgba_word;

    typedef struct {
        t_hsla_word src;
        t_rgba_word rgba;
    } t_pending_color;

    // ------------------------------------------------------------------------
    // Scoreboard: fixed-point color predictor plus in-order compare
    // ------------------------------------------------------------------------
    class rgba_scoreboard;
        t_pending_color color_q[$];
        int             mismatches;

        function new();
            mismatches = 0;
        endfunction

        function int pending();
            return color_q.size();
        endfunction

        function bit [63:0] clamp_frac(bit [FRAC_W-1:0] v);
            return (v > ONE) ? ONE : {47'd0, v};
        endfunction

        function bit [63:0] wrap_turn(bit [63:0] h);
            return (h >= HUE_TURN) ? h - HUE_TURN : h;
        endfunction

        // m1x/m2x are scaled by ONE*ONE; ramp numerator carries an extra x960
        function bit [CHAN_W-1:0] ramp_level(bit [63:0] m1x, bit [63:0] m2x,
                                              bit [63:0] t);
            bit [63:0] diff, num, whole, part, y, r;
            diff = (m2x >= m1x) ? m2x - m1x : 64'd0;
            if (t < HUE_B1)
                num = m1x * HUE_B1 + diff * t;
            else if (t < HUE_B2)
                num = m2x * HUE_B1;
            else if (t < HUE_B3)
                num = m1x * HUE_B1 + diff * (HUE_B3 - t);
            else
                num = m1x * HUE_B1;
            if (num >= (ONE * ONE) * HUE_B1)
                return 8'hFF;
            whole = num / HUE_B1;
            part  = num % HUE_B1;
            y     = 255 * whole + (255 * part) / HUE_B1;
            r     = y >> (2 * FB);
            return (r > 255) ? 8'hFF : r[CHAN_W-1:0];
        endfunction

        function t_rgba_word predict_rgba(t_hsla_word w);
            t_rgba_word o;
            bit [63:0]  h, s, l, a, grey, m1x, m2x, twol, av;
            h = wrap_turn({51'd0, w.hue});
            s = clamp_frac(w.saturation);
            l = clamp_frac(w.lightness);
            a = clamp_frac(w.opacity);
            if (s * GREY_DIV < ONE) begin
                // no saturation: all three channels are the lightness level
                grey = (l * 255) >> FB;
                if (grey > 255)
                    grey = 255;
                o.red   = grey[CHAN_W-1:0];
                o.green = grey[CHAN_W-1:0];
                o.blue  = grey[CHAN_W-1:0];
            end else begin
                if (l <= (ONE >> 1))
                    m2x = l * (s + ONE);
                else
                    m2x = (l + s) * ONE - l * s;
                twol    = 2 * l * ONE;
                m1x     = (twol >= m2x) ? twol - m2x : 64'd0;
                o.red   = ramp_level(m1x, m2x, wrap_turn(h + HUE_THIRD));
                o.green = ramp_level(m1x, m2x, h);
                o.blue  = ramp_level(m1x, m2x, wrap_turn(h + HUE_TURN - HUE_THIRD));
            end
            av = (a * 255) >> FB;
            o.alpha_out = (av > 255) ? 8'hFF : av[CHAN_W-1:0];
            return o;
        endfunction

        function void note_input(t_hsla_word w);
            t_pending_color p;
            p.src  = w;
            p.rgba = predict_rgba(w);
            color_q.push_back(p);
        endfunction

        function void check_result(t_rgba_word got);
            t_pending_color p;
            if (color_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected word r=%0d g=%0d b=%0d a=%0d",
                             got.red, got.green, got.blue, got.alpha_out);
                return;
            end
            p = color_q.pop_front();
            if (got.red !== p.rgba.red || got.green !== p.rgba.green ||
                got.blue !== p.rgba.blue || got.alpha_out !== p.rgba.alpha_out) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: h=%0d s=%0d l=%0d o=%0d ",
                           p.src.hue, p.src.saturation, p.src.lightness,
                           p.src.opacity);
                    $display("exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                             p.rgba.red, p.rgba.green, p.rgba.blue,
                             p.rgba.alpha_out, got.red, got.green, got.blue,
                             got.alpha_out);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    hslc_in_if  hsl_if ();
    hslc_out_if rgba_if ();

    hsl_to_rgba_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsl   (hsl_if),
        .o_rgba  (rgba_if)
    );

    rgba_scoreboard sb = new();

    // idle rates in percent, set per phase by the stimulus
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    // stimulus raises this to ask the output side for a long hold-off
    bit hold_req      = 0;
    int hold_left     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output side: random back-pressure, or a long counted hold-off on request.
    initial begin
        rgba_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                rgba_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req       = 0;
                hold_left      = HOLD_LEN - 1;
                rgba_if.ready <= 1'b0;
            end else begin
                rgba_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Output monitor: every accepted word goes to the scoreboard.
    initial begin
        t_rgba_word got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rgba_if.valid && rgba_if.ready) begin
                got.red       = rgba_if.red;
                got.green     = rgba_if.green;
                got.blue      = rgba_if.blue;
                got.alpha_out = rgba_if.alpha_out;
                sb.check_result(got);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Offer one word; valid stays high from the previous word unless an idle
    // gap is drawn, so back-to-back words see a single assignment per edge.
    task automatic send_word(t_hsla_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            hsl_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        hsl_if.valid      <= 1'b1;
        hsl_if.hue        <= w.hue;
        hsl_if.saturation <= w.saturation;
        hsl_if.lightness  <= w.lightness;
        hsl_if.opacity    <= w.opacity;
        do @(posedge i_clk); while (!hsl_if.ready);
        sb.note_input(w);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        hsl_if.valid <= 1'b0;
    endtask

    // Sender pause: nothing new until every predicted word has come back.
    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_hsla_word make_word(int h, int s, int l, int o);
        t_hsla_word w;
        w.hue        = h[HUE_W-1:0];
        w.saturation = s[FRAC_W-1:0];
        w.lightness  = l[FRAC_W-1:0];
        w.opacity    = o[FRAC_W-1:0];
        return w;
    endfunction

    // Fractions: mostly in range, with weight on zero, one, the grey
    // threshold and values above one that saturate.
    function automatic int rand_frac();
        case ($urandom_range(9))
            0:       return $urandom_range(3);
            1:       return ONE_I - $urandom_range(3);
            2:       return ONE_I;
            3:       return $urandom_range(FRAC_MAX, ONE_I + 1);
            4:       return $urandom_range(FRAC_MAX);
            default: return $urandom_range(ONE_I);
        endcase
    endfunction

    // Hue: uniform over the field, or close to a ramp breakpoint or the wrap.
    function automatic int rand_hue();
        int marks[7] = '{0, HUE_B1, HUE_THIRD, HUE_B2, HUE_B3, 4800, HUE_TURN};
        int h;
        if ($urandom_range(3) == 0) begin
            h = marks[$urandom_range(6)] + $urandom_range(4) - 2;
            if (h < 0)
                h = 0;
            return h;
        end
        return $urandom_range(HUE_MAX);
    endfunction

    task automatic run_phase(int n, int snd_pct, int rcv_pct, bit with_hold);
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        for (int i = 0; i < n; i++) begin
            // a third of the way in, stall the output long enough to fill the pipeline
            if (with_hold && i == n / 3)
                hold_req = 1;
            send_word(make_word(rand_hue(), rand_frac(), rand_frac(), rand_frac()));
        end
        stop_sending();
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        t_hsla_word directed[$];

        i_rst_n           = 1'b0;
        hsl_if.valid      = 1'b0;
        hsl_if.hue        = '0;
        hsl_if.saturation = '0;
        hsl_if.lightness  = '0;
        hsl_if.opacity    = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // primaries and ramp breakpoints at full saturation, half lightness
        directed.push_back(make_word(0,         ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(959,       ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(HUE_B1,    ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(HUE_THIRD, ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(2879,      ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(HUE_B2,    ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(3839,      ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(HUE_B3,    ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(5759,      ONE_I, ONE_I / 2, ONE_I));
        // hue past a full turn wraps once
        directed.push_back(make_word(HUE_TURN,  ONE_I, ONE_I / 2, ONE_I));
        directed.push_back(make_word(HUE_MAX,   ONE_I, ONE_I / 2, ONE_I));
        // zero saturation gives grey; the smallest nonzero one does not
        directed.push_back(make_word(1234, 0, 0,        ONE_I));
        directed.push_back(make_word(1234, 0, ONE_I,    ONE_I));
        directed.push_back(make_word(1234, 0, 12345,    0));
        directed.push_back(make_word(1234, 0, FRAC_MAX, ONE_I));
        directed.push_back(make_word(1234, 1, 40000,    ONE_I));
        // lightness on both sides of one half, and saturating fields
        directed.push_back(make_word(700,  40000,    ONE_I / 2,     ONE_I - 1));
        directed.push_back(make_word(700,  40000,    ONE_I / 2 + 1, 1));
        directed.push_back(make_word(3000, FRAC_MAX, 20000,         FRAC_MAX));
        directed.push_back(make_word(4500, 30000,    FRAC_MAX,      ONE_I + 1));
        directed.push_back(make_word(HUE_MAX, FRAC_MAX, FRAC_MAX, FRAC_MAX));
        directed.push_back(make_word(0, 0, 0, 0));

        foreach (directed[i])
            send_word(directed[i]);
        stop_sending();
        wait_drained();

        // sender idles 20%, receiver 59%; then swapped; then no idling
        run_phase(PHASE_N, 20, 59, 1'b1);
        run_phase(PHASE_N, 59, 20, 1'b0);
        run_phase(PHASE_N, 0,  0,  1'b1);

        // let any stray word surface after the last expected one
        repeat (16) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
